// ===== hw/rtl/mdu_pkg.sv =====
// ----------------------------------------------------------------------------
// mdu_pkg: shared types and constants of the RV64M multiply/divide unit
// Operation codes, the classified request carried between front and back,
// and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package mdu_pkg;

  localparam int unsigned XLEN        = 64;
  localparam int unsigned HALF        = XLEN / 2;
  localparam int unsigned REG_W       = 5;
  localparam int unsigned OP_W        = 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = 6;

  localparam logic [XLEN-1:0] SIGN64    = {1'b1, {(XLEN-1){1'b0}}};
  localparam logic [XLEN-1:0] ALL_ONES  = {XLEN{1'b1}};
  localparam logic [XLEN-1:0] W_OVF_RES = 64'hffff_ffff_8000_0000;
  localparam logic [HALF-1:0] SIGN32    = {1'b1, {(HALF-1){1'b0}}};

  localparam logic [CNT_W-1:0] MUL_LAST = 6'd4;
  localparam logic [CNT_W-1:0] DIV_LAST = 6'd63;

  typedef enum logic [OP_W-1:0] {
    OP_MUL    = 4'd0,
    OP_MULH   = 4'd1,
    OP_MULHSU = 4'd2,
    OP_MULHU  = 4'd3,
    OP_DIV    = 4'd4,
    OP_DIVU   = 4'd5,
    OP_REM    = 4'd6,
    OP_REMU   = 4'd7,
    OP_MULW   = 4'd8,
    OP_DIVW   = 4'd9,
    OP_DIVUW  = 4'd10,
    OP_REMW   = 4'd11,
    OP_REMUW  = 4'd12
  } op_e;

  typedef enum logic [1:0] {
    KIND_MUL,
    KIND_DIV,
    KIND_FIX
  } kind_e;

  typedef enum logic [2:0] {
    SEL_LO,
    SEL_HI,
    SEL_QUO,
    SEL_REM,
    SEL_FIX
  } sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    kind_e            kind;
    sel_e             sel;
    logic             w;
    logic             neg_q;
    logic             neg_r;
    logic             dz;
    logic             ov;
    logic [REG_W-1:0] rd;
    logic [XLEN-1:0]  opa;
    logic [XLEN-1:0]  opb;
    logic [XLEN-1:0]  aux;
  } item_t;

  function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] v);
    return {{HALF{v[HALF-1]}}, v[HALF-1:0]};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mdu_front.sv =====
// ----------------------------------------------------------------------------
// mdu_front: request classifier
// Decodes the operation, settles zero-divisor and overflow cases at once and
// prepares operand magnitudes, signs and the high-product correction.
// ----------------------------------------------------------------------------
`default_nettype none

module mdu_front (
  input  wire logic [mdu_pkg::OP_W-1:0]  op_i,
  input  wire logic [mdu_pkg::XLEN-1:0]  operand_a_i,
  input  wire logic [mdu_pkg::XLEN-1:0]  operand_b_i,
  input  wire logic [mdu_pkg::REG_W-1:0] dest_reg_i,
  output mdu_pkg::item_t                 item_o
);

  logic                     w_form;
  logic [mdu_pkg::XLEN-1:0] sa;
  logic [mdu_pkg::XLEN-1:0] sb;
  logic [mdu_pkg::XLEN-1:0] ma;
  logic [mdu_pkg::XLEN-1:0] mb;
  logic [mdu_pkg::XLEN-1:0] za;
  logic [mdu_pkg::XLEN-1:0] zb;
  logic [mdu_pkg::XLEN-1:0] a_sx;
  logic                     b_zero;
  logic                     b32_zero;
  logic                     d_ovf;
  logic                     w_ovf;

  assign w_form   = op_i[3];
  assign a_sx     = mdu_pkg::sext32(operand_a_i);
  assign sa       = w_form ? a_sx : operand_a_i;
  assign sb       = w_form ? mdu_pkg::sext32(operand_b_i) : operand_b_i;
  assign ma       = sa[mdu_pkg::XLEN-1] ? (~sa + 64'd1) : sa;
  assign mb       = sb[mdu_pkg::XLEN-1] ? (~sb + 64'd1) : sb;
  assign za       = {{mdu_pkg::HALF{1'b0}}, operand_a_i[mdu_pkg::HALF-1:0]};
  assign zb       = {{mdu_pkg::HALF{1'b0}}, operand_b_i[mdu_pkg::HALF-1:0]};
  assign b_zero   = (operand_b_i == '0);
  assign b32_zero = (operand_b_i[mdu_pkg::HALF-1:0] == '0);
  assign d_ovf    = (operand_a_i == mdu_pkg::SIGN64) && (operand_b_i == mdu_pkg::ALL_ONES);
  assign w_ovf    = (operand_a_i[mdu_pkg::HALF-1:0] == mdu_pkg::SIGN32)
                 && (operand_b_i[mdu_pkg::HALF-1:0] == {mdu_pkg::HALF{1'b1}});

  always_comb begin
    item_o       = '0;
    item_o.rd    = dest_reg_i;
    item_o.kind  = mdu_pkg::KIND_FIX;
    item_o.sel   = mdu_pkg::SEL_FIX;
    item_o.opa   = operand_a_i;
    item_o.opb   = operand_b_i;
    case (op_i)
      mdu_pkg::OP_MUL: begin
        item_o.kind = mdu_pkg::KIND_MUL;
        item_o.sel  = mdu_pkg::SEL_LO;
      end
      mdu_pkg::OP_MULH: begin
        item_o.kind = mdu_pkg::KIND_MUL;
        item_o.sel  = mdu_pkg::SEL_HI;
        item_o.aux  = (operand_a_i[mdu_pkg::XLEN-1] ? operand_b_i : '0)
                    + (operand_b_i[mdu_pkg::XLEN-1] ? operand_a_i : '0);
      end
      mdu_pkg::OP_MULHSU: begin
        item_o.kind = mdu_pkg::KIND_MUL;
        item_o.sel  = mdu_pkg::SEL_HI;
        item_o.aux  = operand_a_i[mdu_pkg::XLEN-1] ? operand_b_i : '0;
      end
      mdu_pkg::OP_MULHU: begin
        item_o.kind = mdu_pkg::KIND_MUL;
        item_o.sel  = mdu_pkg::SEL_HI;
      end
      mdu_pkg::OP_MULW: begin
        item_o.kind = mdu_pkg::KIND_MUL;
        item_o.sel  = mdu_pkg::SEL_LO;
        item_o.w    = 1'b1;
        item_o.opa  = za;
        item_o.opb  = zb;
      end
      mdu_pkg::OP_DIV, mdu_pkg::OP_REM: begin
        if (b_zero) begin
          item_o.dz  = 1'b1;
          item_o.aux = (op_i == mdu_pkg::OP_DIV) ? mdu_pkg::ALL_ONES : operand_a_i;
        end else if (d_ovf) begin
          item_o.ov  = 1'b1;
          item_o.aux = (op_i == mdu_pkg::OP_DIV) ? mdu_pkg::SIGN64 : '0;
        end else begin
          item_o.kind  = mdu_pkg::KIND_DIV;
          item_o.sel   = (op_i == mdu_pkg::OP_DIV) ? mdu_pkg::SEL_QUO : mdu_pkg::SEL_REM;
          item_o.opa   = ma;
          item_o.opb   = mb;
          item_o.neg_q = sa[mdu_pkg::XLEN-1] ^ sb[mdu_pkg::XLEN-1];
          item_o.neg_r = sa[mdu_pkg::XLEN-1];
        end
      end
      mdu_pkg::OP_DIVU, mdu_pkg::OP_REMU: begin
        if (b_zero) begin
          item_o.dz  = 1'b1;
          item_o.aux = (op_i == mdu_pkg::OP_DIVU) ? mdu_pkg::ALL_ONES : operand_a_i;
        end else begin
          item_o.kind = mdu_pkg::KIND_DIV;
          item_o.sel  = (op_i == mdu_pkg::OP_DIVU) ? mdu_pkg::SEL_QUO : mdu_pkg::SEL_REM;
        end
      end
      mdu_pkg::OP_DIVW, mdu_pkg::OP_REMW: begin
        if (b32_zero) begin
          item_o.dz  = 1'b1;
          item_o.aux = (op_i == mdu_pkg::OP_DIVW) ? mdu_pkg::ALL_ONES : a_sx;
        end else if (w_ovf) begin
          item_o.ov  = 1'b1;
          item_o.aux = (op_i == mdu_pkg::OP_DIVW) ? mdu_pkg::W_OVF_RES : '0;
        end else begin
          item_o.kind  = mdu_pkg::KIND_DIV;
          item_o.sel   = (op_i == mdu_pkg::OP_DIVW) ? mdu_pkg::SEL_QUO : mdu_pkg::SEL_REM;
          item_o.w     = 1'b1;
          item_o.opa   = ma;
          item_o.opb   = mb;
          item_o.neg_q = sa[mdu_pkg::XLEN-1] ^ sb[mdu_pkg::XLEN-1];
          item_o.neg_r = sa[mdu_pkg::XLEN-1];
        end
      end
      mdu_pkg::OP_DIVUW, mdu_pkg::OP_REMUW: begin
        if (b32_zero) begin
          item_o.dz  = 1'b1;
          item_o.aux = (op_i == mdu_pkg::OP_DIVUW) ? mdu_pkg::ALL_ONES : a_sx;
        end else begin
          item_o.kind = mdu_pkg::KIND_DIV;
          item_o.sel  = (op_i == mdu_pkg::OP_DIVUW) ? mdu_pkg::SEL_QUO : mdu_pkg::SEL_REM;
          item_o.w    = 1'b1;
          item_o.opa  = za;
          item_o.opb  = zb;
        end
      end
      default: begin
        item_o.aux = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mdu_queue.sv =====
// ----------------------------------------------------------------------------
// mdu_queue: request queue between front and back
// Small register FIFO holding classified requests.
// ----------------------------------------------------------------------------
`default_nettype none

module mdu_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  mdu_pkg::item_t    wr_item_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              empty_o,
  output mdu_pkg::item_t    rd_item_o
);

  mdu_pkg::item_t                mem_q [mdu_pkg::QUEUE_DEPTH];
  logic [mdu_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [mdu_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [mdu_pkg::QPTR_W:0]      cnt_q, cnt_d;
  logic                          do_push;
  logic                          do_pop;

  assign full_o    = (cnt_q == mdu_pkg::QPTR_W'(0) + (mdu_pkg::QPTR_W+1)'(mdu_pkg::QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign rd_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (mdu_pkg::QPTR_W+1)'(do_push) - (mdu_pkg::QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mdu_back.sv =====
// ----------------------------------------------------------------------------
// mdu_back: execution sequencer
// Runs one request at a time: four 32x32 partial products for multiplies,
// a radix-2 restoring loop for divides, then sign fix-up into the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module mdu_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      q_empty_i,
  input  mdu_pkg::item_t                 q_item_i,
  output logic                           q_pop_o,
  input  wire logic                      pop_i,
  output logic                           empty_o,
  output logic [mdu_pkg::XLEN-1:0]       result_o,
  output logic [mdu_pkg::REG_W-1:0]      result_reg_o,
  output logic                           divide_by_zero_o,
  output logic                           div_overflow_o
);

  mdu_pkg::state_e               state_q, state_d;
  mdu_pkg::item_t                item_q, item_d;
  logic [mdu_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [2*mdu_pkg::XLEN-1:0]    acc_q, acc_d;
  logic [mdu_pkg::XLEN-1:0]      pp_q, pp_d;
  logic [1:0]                    sh_q, sh_d;
  logic [mdu_pkg::XLEN-1:0]      rem_q, rem_d;
  logic [mdu_pkg::XLEN-1:0]      quo_q, quo_d;
  logic                          out_valid_q, out_valid_d;
  logic [mdu_pkg::XLEN-1:0]      res_q, res_d;
  logic [mdu_pkg::REG_W-1:0]     rd_q, rd_d;
  logic                          dz_q, dz_d;
  logic                          ov_q, ov_d;

  logic                          out_free;
  logic [mdu_pkg::HALF-1:0]      mul_a;
  logic [mdu_pkg::HALF-1:0]      mul_b;
  logic [2*mdu_pkg::XLEN-1:0]    pp_shifted;
  logic [mdu_pkg::XLEN:0]        rem_sh;
  logic [mdu_pkg::XLEN:0]        rem_diff;
  logic                          rem_ge;
  logic [mdu_pkg::XLEN-1:0]      fin_res;

  assign out_free = !out_valid_q || pop_i;

  // partial product order: lo*lo, lo*hi, hi*lo, hi*hi
  assign mul_a = cnt_q[1] ? item_q.opa[mdu_pkg::XLEN-1:mdu_pkg::HALF]
                          : item_q.opa[mdu_pkg::HALF-1:0];
  assign mul_b = cnt_q[0] ? item_q.opb[mdu_pkg::XLEN-1:mdu_pkg::HALF]
                          : item_q.opb[mdu_pkg::HALF-1:0];
  assign pp_shifted = {{mdu_pkg::XLEN{1'b0}}, pp_q} << (mdu_pkg::HALF * sh_q);

  assign rem_sh   = {rem_q, quo_q[mdu_pkg::XLEN-1]};
  assign rem_diff = rem_sh - {1'b0, item_q.opb};
  assign rem_ge   = (rem_sh >= {1'b0, item_q.opb});

  always_comb begin
    case (item_q.sel)
      mdu_pkg::SEL_LO:  fin_res = acc_q[mdu_pkg::XLEN-1:0];
      mdu_pkg::SEL_HI:  fin_res = acc_q[2*mdu_pkg::XLEN-1:mdu_pkg::XLEN] - item_q.aux;
      mdu_pkg::SEL_QUO: fin_res = item_q.neg_q ? (~quo_q + 64'd1) : quo_q;
      mdu_pkg::SEL_REM: fin_res = item_q.neg_r ? (~rem_q + 64'd1) : rem_q;
      default:          fin_res = item_q.aux;
    endcase
    if (item_q.w) begin
      fin_res = mdu_pkg::sext32(fin_res);
    end
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    pp_d        = pp_q;
    sh_d        = sh_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    out_valid_d = out_valid_q && !pop_i;
    res_d       = res_q;
    rd_d        = rd_q;
    dz_d        = dz_q;
    ov_d        = ov_q;
    q_pop_o     = 1'b0;
    case (state_q)
      mdu_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          cnt_d   = '0;
          acc_d   = '0;
          rem_d   = '0;
          quo_d   = q_item_i.opa;
          case (q_item_i.kind)
            mdu_pkg::KIND_MUL: state_d = mdu_pkg::ST_MUL;
            mdu_pkg::KIND_DIV: state_d = mdu_pkg::ST_DIV;
            default:           state_d = mdu_pkg::ST_FIN;
          endcase
        end
      end
      mdu_pkg::ST_MUL: begin
        // accumulate the previous product while forming the next
        if (cnt_q != '0) begin
          acc_d = acc_q + pp_shifted;
        end
        pp_d  = mul_a * mul_b;
        sh_d  = 2'(cnt_q[1]) + 2'(cnt_q[0]);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == mdu_pkg::MUL_LAST) begin
          state_d = mdu_pkg::ST_FIN;
        end
      end
      mdu_pkg::ST_DIV: begin
        rem_d = rem_ge ? rem_diff[mdu_pkg::XLEN-1:0] : rem_sh[mdu_pkg::XLEN-1:0];
        quo_d = {quo_q[mdu_pkg::XLEN-2:0], rem_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == mdu_pkg::DIV_LAST) begin
          state_d = mdu_pkg::ST_FIN;
        end
      end
      mdu_pkg::ST_FIN: begin
        // hold here until the result register can take it
        if (out_free) begin
          out_valid_d = 1'b1;
          res_d       = fin_res;
          rd_d        = item_q.rd;
          dz_d        = item_q.dz;
          ov_d        = item_q.ov;
          state_d     = mdu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mdu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mdu_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    acc_q  <= acc_d;
    pp_q   <= pp_d;
    sh_q   <= sh_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    res_q  <= res_d;
    rd_q   <= rd_d;
    dz_q   <= dz_d;
    ov_q   <= ov_d;
  end

  assign empty_o          = !out_valid_q;
  assign result_o         = res_q;
  assign result_reg_o     = rd_q;
  assign divide_by_zero_o = dz_q;
  assign div_overflow_o   = ov_q;

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mdu_pkg::ST_MUL) |-> (cnt_q <= mdu_pkg::MUL_LAST))
    else $error("multiply step count out of range");

  a_div_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mdu_pkg::ST_DIV) |->
      (item_q.sel == mdu_pkg::SEL_QUO || item_q.sel == mdu_pkg::SEL_REM))
    else $error("divide loop running on a non-divide request");

  a_take_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mdu_pkg::ST_IDLE && !q_empty_i) |=> (state_q != mdu_pkg::ST_IDLE))
    else $error("waiting request not taken");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mdu_pkg::ST_FIN && out_free) |=> out_valid_q)
    else $error("finished result not loaded");

endmodule

`default_nettype wire

// ===== hw/rtl/rv64m_multiply_divide_unit_core.sv =====
// ----------------------------------------------------------------------------
// rv64m_multiply_divide_unit_core: RV64M multiply/divide execution unit
// Requests enter through a push/full queue port; results leave through an
// empty/pop queue port, oldest first.
// A request is taken when push is high and full low. The front decodes it
// and settles zero-divisor and overflow cases at once; a four-entry queue
// lets requests keep arriving while the back is busy.
// The back runs one request at a time. Zero-divisor, overflow and unused
// codes skip the arithmetic; multiplies form four 32x32 partial products on
// one multiplier, and divides and remainders run a restoring loop that
// produces one quotient bit per cycle.
// A finished result waits in the output register while the back starts the
// next request; if pop stays low the back holds its next result and the
// queue fills, after which full goes high.
// Reset clears the queue and the output register; empty is high and full
// low straight after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64m_multiply_divide_unit_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [mdu_pkg::OP_W-1:0]      op_i,
  input  wire logic [mdu_pkg::XLEN-1:0]      operand_a_i,
  input  wire logic [mdu_pkg::XLEN-1:0]      operand_b_i,
  input  wire logic [mdu_pkg::REG_W-1:0]     dest_reg_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [mdu_pkg::XLEN-1:0]           result_o,
  output logic [mdu_pkg::REG_W-1:0]          result_reg_o,
  output logic                               divide_by_zero_o,
  output logic                               div_overflow_o
);

  mdu_pkg::item_t front_item;
  mdu_pkg::item_t head_item;
  logic           q_empty;
  logic           q_pop;

  mdu_front u_front (
    .op_i        (op_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .dest_reg_i  (dest_reg_i),
    .item_o      (front_item)
  );

  mdu_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_item_i (front_item),
    .full_o    (full),
    .pop_i     (q_pop),
    .empty_o   (q_empty),
    .rd_item_o (head_item)
  );

  mdu_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_item_i         (head_item),
    .q_pop_o          (q_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .result_o         (result_o),
    .result_reg_o     (result_reg_o),
    .divide_by_zero_o (divide_by_zero_o),
    .div_overflow_o   (div_overflow_o)
  );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RV64M multiply/divide unit
// Drives directed and random requests through the push/full port, pops
// results with random stalls and compares each one with a local model of
// the RV64M arithmetic, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int unsigned RANDOM_REQS = 1800;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned LONG_HOLD   = 600;
  localparam logic [3:0]  OP_UNUSED   = 4'd13;

  typedef struct {
    logic [mdu_pkg::XLEN-1:0]  res;
    logic [mdu_pkg::REG_W-1:0] rd;
    logic                      dz;
    logic                      ov;
  } mdu_res_t;

  typedef struct {
    logic [3:0]                op;
    logic [mdu_pkg::XLEN-1:0]  a;
    logic [mdu_pkg::XLEN-1:0]  b;
    logic                      known;
    logic [mdu_pkg::XLEN-1:0]  res;
    logic                      dz;
    logic                      ov;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [mdu_pkg::OP_W-1:0] op_i = '0;
  logic [mdu_pkg::XLEN-1:0] operand_a_i = '0;
  logic [mdu_pkg::XLEN-1:0] operand_b_i = '0;
  logic [mdu_pkg::REG_W-1:0] dest_reg_i = '0;
  logic full, empty, divide_by_zero_o, div_overflow_o;
  logic [mdu_pkg::XLEN-1:0] result_o;
  logic [mdu_pkg::REG_W-1:0] result_reg_o;

  mdu_res_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_pop = 1'b0;

  rv64m_multiply_divide_unit_core i_dut (
    .clk_i, .rst_ni, .push, .full, .op_i, .operand_a_i, .operand_b_i,
    .dest_reg_i, .empty, .pop, .result_o, .result_reg_o,
    .divide_by_zero_o, .div_overflow_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [mdu_pkg::XLEN-1:0] sx32(input logic [mdu_pkg::XLEN-1:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  // Exact RV64M semantics, computed with wide arithmetic.
  function automatic mdu_res_t mdu_compute(input logic [3:0] op,
                                           input logic [mdu_pkg::XLEN-1:0] a,
                                           input logic [mdu_pkg::XLEN-1:0] b,
                                           input logic [mdu_pkg::REG_W-1:0] rd);
    mdu_res_t r;
    logic signed [127:0] prod;
    logic [31:0] a32, b32;
    logic signed [63:0] sa, sb;
    a32 = a[31:0];
    b32 = b[31:0];
    r.res = '0;
    r.rd = rd;
    r.dz = 1'b0;
    r.ov = 1'b0;
    case (op)
      mdu_pkg::OP_MUL:    r.res = a * b;
      mdu_pkg::OP_MULH: begin
        prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        r.res = prod[127:64];
      end
      mdu_pkg::OP_MULHSU: begin
        prod = $signed({{64{a[63]}}, a}) * $signed({64'd0, b});
        r.res = prod[127:64];
      end
      mdu_pkg::OP_MULHU: begin
        prod = {64'd0, a} * {64'd0, b};
        r.res = prod[127:64];
      end
      mdu_pkg::OP_DIV, mdu_pkg::OP_REM: begin
        if (b == '0) begin
          r.dz = 1'b1;
          r.res = (op == mdu_pkg::OP_DIV) ? mdu_pkg::ALL_ONES : a;
        end else if (a == mdu_pkg::SIGN64 && b == mdu_pkg::ALL_ONES) begin
          r.ov = 1'b1;
          r.res = (op == mdu_pkg::OP_DIV) ? mdu_pkg::SIGN64 : '0;
        end else begin
          sa = a;
          sb = b;
          r.res = (op == mdu_pkg::OP_DIV) ? sa / sb : sa % sb;
        end
      end
      mdu_pkg::OP_DIVU, mdu_pkg::OP_REMU: begin
        if (b == '0) begin
          r.dz = 1'b1;
          r.res = (op == mdu_pkg::OP_DIVU) ? mdu_pkg::ALL_ONES : a;
        end else r.res = (op == mdu_pkg::OP_DIVU) ? a / b : a % b;
      end
      mdu_pkg::OP_MULW: r.res = sx32(a * b);
      mdu_pkg::OP_DIVW, mdu_pkg::OP_REMW: begin
        if (b32 == '0) begin
          r.dz = 1'b1;
          r.res = (op == mdu_pkg::OP_DIVW) ? mdu_pkg::ALL_ONES : sx32(a);
        end else if (a32 == 32'h8000_0000 && b32 == 32'hffff_ffff) begin
          r.ov = 1'b1;
          r.res = (op == mdu_pkg::OP_DIVW) ? mdu_pkg::W_OVF_RES : '0;
        end else begin
          sa = sx32(a);
          sb = sx32(b);
          r.res = sx32((op == mdu_pkg::OP_DIVW) ? sa / sb : sa % sb);
        end
      end
      mdu_pkg::OP_DIVUW, mdu_pkg::OP_REMUW: begin
        if (b32 == '0) begin
          r.dz = 1'b1;
          r.res = (op == mdu_pkg::OP_DIVUW) ? mdu_pkg::ALL_ONES : sx32(a);
        end else r.res = sx32(64'((op == mdu_pkg::OP_DIVUW) ? a32 / b32 : a32 % b32));
      end
      default: r.res = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [mdu_pkg::XLEN-1:0] got,
                                 input logic [mdu_pkg::XLEN-1:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  function automatic logic [mdu_pkg::XLEN-1:0] rand_operand();
    logic [mdu_pkg::XLEN-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = mdu_pkg::ALL_ONES;
      2: v = mdu_pkg::SIGN64;
      3: v = {32'($urandom), 32'h8000_0000};
      4: v = {32'($urandom), 32'hffff_ffff};
      5: v = {32'($urandom), 32'd0};
      6: v = mdu_pkg::XLEN'($urandom_range(0, 20));
      default: ;
    endcase
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [3:0] op, input logic [mdu_pkg::XLEN-1:0] a,
                              input logic [mdu_pkg::XLEN-1:0] b,
                              input logic [mdu_pkg::REG_W-1:0] rd);
    int unsigned gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    op_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    dest_reg_i <= rd;
    pending_results.push_back(mdu_compute(op, a, b, rd));
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stimulus.
  initial begin
    dir_row_t rows[$];
    mdu_res_t want;
    logic [3:0] op;
    rows.push_back('{mdu_pkg::OP_MUL, mdu_pkg::ALL_ONES, mdu_pkg::ALL_ONES, 1'b1, 64'd1,
                     1'b0, 1'b0});
    rows.push_back('{mdu_pkg::OP_MULH, mdu_pkg::SIGN64, mdu_pkg::SIGN64, 1'b1,
                     64'h4000_0000_0000_0000, 1'b0, 1'b0});
    rows.push_back('{mdu_pkg::OP_MULHSU, mdu_pkg::ALL_ONES, mdu_pkg::ALL_ONES, 1'b1,
                     mdu_pkg::ALL_ONES, 1'b0, 1'b0});
    rows.push_back('{mdu_pkg::OP_MULHU, mdu_pkg::ALL_ONES, mdu_pkg::ALL_ONES, 1'b1,
                     64'hffff_ffff_ffff_fffe, 1'b0, 1'b0});
    rows.push_back('{mdu_pkg::OP_MULHSU, mdu_pkg::SIGN64, 64'd3, 1'b0, '0, 1'b0, 1'b0});
    rows.push_back('{mdu_pkg::OP_DIV, 64'd7, 64'd0, 1'b1, mdu_pkg::ALL_ONES, 1'b1, 1'b0});
    rows.push_back('{mdu_pkg::OP_DIV, mdu_pkg::SIGN64, mdu_pkg::ALL_ONES, 1'b1,
                     mdu_pkg::SIGN64, 1'b0, 1'b1});
    rows.push_back('{mdu_pkg::OP_DIV, -64'sd7, 64'd2, 1'b0, '0, 1'b0, 1'b0});
    rows.push_back('{mdu_pkg::OP_DIVU, mdu_pkg::ALL_ONES, 64'd0, 1'b1, mdu_pkg::ALL_ONES,
                     1'b1, 1'b0});
    rows.push_back('{mdu_pkg::OP_DIVU, mdu_pkg::ALL_ONES, 64'd3, 1'b0, '0, 1'b0, 1'b0});
    rows.push_back('{mdu_pkg::OP_REM, 64'd9, 64'd0, 1'b1, 64'd9, 1'b1, 1'b0});
    rows.push_back('{mdu_pkg::OP_REM, mdu_pkg::SIGN64, mdu_pkg::ALL_ONES, 1'b1, 64'd0,
                     1'b0, 1'b1});
    rows.push_back('{mdu_pkg::OP_REM, -64'sd7, 64'd2, 1'b0, '0, 1'b0, 1'b0});
    rows.push_back('{mdu_pkg::OP_REMU, 64'd5, 64'd0, 1'b1, 64'd5, 1'b1, 1'b0});
    rows.push_back('{mdu_pkg::OP_REMU, mdu_pkg::ALL_ONES, 64'd10, 1'b0, '0, 1'b0, 1'b0});
    rows.push_back('{mdu_pkg::OP_MULW, 64'h1_8000_0000, 64'h5_0000_0001, 1'b0, '0, 1'b0,
                     1'b0});
    rows.push_back('{mdu_pkg::OP_DIVW, 64'd3, 64'h7_0000_0000, 1'b1, mdu_pkg::ALL_ONES,
                     1'b1, 1'b0});
    rows.push_back('{mdu_pkg::OP_DIVW, 64'h5_8000_0000, 64'h1_ffff_ffff, 1'b1,
                     mdu_pkg::W_OVF_RES, 1'b0, 1'b1});
    rows.push_back('{mdu_pkg::OP_DIVUW, 64'h9_ffff_ffff, 64'd1, 1'b1, mdu_pkg::ALL_ONES,
                     1'b0, 1'b0});
    rows.push_back('{mdu_pkg::OP_DIVUW, 64'd1, 64'hf_0000_0000, 1'b1, mdu_pkg::ALL_ONES,
                     1'b1, 1'b0});
    rows.push_back('{mdu_pkg::OP_REMW, 64'h8000_0000, 64'd0, 1'b1, mdu_pkg::W_OVF_RES,
                     1'b1, 1'b0});
    rows.push_back('{mdu_pkg::OP_REMW, 64'h8000_0000, 64'hffff_ffff, 1'b1, 64'd0, 1'b0,
                     1'b1});
    rows.push_back('{mdu_pkg::OP_REMUW, 64'hffff_fffe, 64'd0, 1'b1, 64'hffff_ffff_ffff_fffe,
                     1'b1, 1'b0});
    rows.push_back('{mdu_pkg::OP_REMUW, 64'hffff_ffff, 64'h7fff_ffff, 1'b0, '0, 1'b0,
                     1'b0});
    rows.push_back('{OP_UNUSED, mdu_pkg::ALL_ONES, mdu_pkg::ALL_ONES, 1'b1, 64'd0, 1'b0,
                     1'b0});
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    if (!empty || full) begin
      report_mismatch("empty/full after reset", mdu_pkg::XLEN'({empty, full}),
                      mdu_pkg::XLEN'(2'b10));
    end
    foreach (rows[i]) begin
      if (rows[i].known) begin
        want = mdu_compute(rows[i].op, rows[i].a, rows[i].b, 5'(i));
        if (want.res != rows[i].res || want.dz != rows[i].dz || want.ov != rows[i].ov) begin
          report_mismatch($sformatf("table row %0d", i), want.res, rows[i].res);
        end
      end
      send_request(rows[i].op, rows[i].a, rows[i].b, 5'(i));
    end
    for (int n = 0; n < RANDOM_REQS; n++) begin
      op = ($urandom_range(0, 40) == 0) ? 4'($urandom_range(13, 15))
                                        : 4'($urandom_range(0, 12));
      // Long receiver stall once, to fill the queue and raise full.
      if (n == 200) hold_pop = 1'b1;
      send_request(op, rand_operand(), rand_operand(), 5'($urandom));
    end
    push <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: wait a drawn number of cycles before each pop.
  initial begin
    int unsigned wait_cycles;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      wait_cycles = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) wait_cycles = 0;
      if (hold_pop) begin
        wait_cycles = LONG_HOLD;
        hold_pop = 1'b0;
      end
      if (wait_cycles != 0) begin
        pop <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  // Check results and watch for a stall.
  always @(posedge clk_i) begin
    mdu_res_t want;
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", result_o, '0);
        end else begin
          want = pending_results.pop_front();
          if (result_o !== want.res) report_mismatch("result", result_o, want.res);
          if (result_reg_o !== want.rd)
            report_mismatch("result_reg", mdu_pkg::XLEN'(result_reg_o),
                            mdu_pkg::XLEN'(want.rd));
          if (divide_by_zero_o !== want.dz)
            report_mismatch("divide_by_zero", mdu_pkg::XLEN'(divide_by_zero_o),
                            mdu_pkg::XLEN'(want.dz));
          if (div_overflow_o !== want.ov)
            report_mismatch("div_overflow", mdu_pkg::XLEN'(div_overflow_o),
                            mdu_pkg::XLEN'(want.ov));
        end
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    while (!(stim_done && pending_results.size() == 0) && idle_cycles < IDLE_LIMIT)
      @(posedge clk_i);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      repeat (100) @(posedge clk_i);
      if (error_count == 0 && empty) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
    end
  end
endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/mdu_pkg.sv
hw/rtl/mdu_front.sv
hw/rtl/mdu_queue.sv
hw/rtl/mdu_back.sv
hw/rtl/rv64m_multiply_divide_unit_core.sv
verif/testbench.sv
